### rtl/rset_pkg.sv
package rset_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RND_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PICK   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_NOP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_INS,
    S_SCAN_RMV,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PICK_MOD,
    S_PICK_CAP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] item_value;
    logic [RND_W-1:0]          random_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] picked_value;
    logic [COUNT_W-1:0]        count_after;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    append;
    logic    last_rd;
    logic    move_wr;
    logic    pick_rd;
    logic    pick_cap;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic full;
    logic empty;
    logic mod_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/rset_ram.sv
module rset_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rset_mod.sv
module rset_mod #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rset_pkg::RND_W-1:0]      dividend_i,
  input  logic [$clog2(CAPACITY+1)-1:0]   divisor_i,
  output logic                            done_o,
  output logic [$clog2(CAPACITY+1)-1:0]   rem_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = $clog2(rset_pkg::RND_W + 1);

  logic [CW-1:0]              rem_q, rem_d;
  logic [rset_pkg::RND_W-1:0] shift_q, shift_d;
  logic [NW-1:0]              cnt_q, cnt_d;
  logic [CW:0]                trial;

  // one restoring step per cycle, msb first
  always_comb begin
    trial   = {rem_q, shift_q[rset_pkg::RND_W-1]};
    rem_d   = rem_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      rem_d   = '0;
      shift_d = dividend_i;
      cnt_d   = NW'(rset_pkg::RND_W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = CW'(trial);
      end
      shift_d = {shift_q[rset_pkg::RND_W-2:0], 1'b0};
      cnt_d   = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
  end

  assign done_o = (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

### rtl/rset_ctrl.sv
module rset_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [rset_pkg::KIND_W-1:0]   in_kind_i,
  input  rset_pkg::sts_t                sts_i,
  output rset_pkg::cmd_t                cmd_o,
  output logic                          in_stall_o
);

  rset_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rset_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == rset_pkg::KIND_INSERT) begin
            state_d = rset_pkg::S_SCAN_INS;
          end else if (in_kind_i == rset_pkg::KIND_REMOVE) begin
            state_d = rset_pkg::S_SCAN_RMV;
          end else if (in_kind_i == rset_pkg::KIND_PICK) begin
            state_d = rset_pkg::S_PICK_MOD;
          end else begin
            state_d = rset_pkg::S_FINISH;
          end
        end
      end
      rset_pkg::S_SCAN_INS: begin
        if (sts_i.scan_done) begin
          state_d = rset_pkg::S_FINISH;
        end
      end
      rset_pkg::S_SCAN_RMV: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.hit ? rset_pkg::S_MOVE_RD : rset_pkg::S_FINISH;
        end
      end
      rset_pkg::S_MOVE_RD: state_d = rset_pkg::S_MOVE_WR;
      rset_pkg::S_MOVE_WR: state_d = rset_pkg::S_FINISH;
      rset_pkg::S_PICK_MOD: begin
        if (sts_i.empty) begin
          state_d = rset_pkg::S_FINISH;
        end else if (sts_i.mod_done) begin
          state_d = rset_pkg::S_PICK_CAP;
        end
      end
      rset_pkg::S_PICK_CAP: state_d = rset_pkg::S_FINISH;
      rset_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = rset_pkg::S_IDLE;
        end
      end
      default: state_d = rset_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.status = rset_pkg::STATUS_NOP;
    in_stall_o = 1'b1;
    case (state_q)
      rset_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      rset_pkg::S_SCAN_INS: begin
        cmd_o.scan = !sts_i.scan_done;
        if (sts_i.scan_done && !sts_i.hit) begin
          cmd_o.set_status = 1'b1;
          if (sts_i.full) begin
            cmd_o.status = rset_pkg::STATUS_FULL;
          end else begin
            cmd_o.status = rset_pkg::STATUS_DONE;
            cmd_o.append = 1'b1;
          end
        end
      end
      rset_pkg::S_SCAN_RMV: cmd_o.scan = !sts_i.scan_done;
      rset_pkg::S_MOVE_RD:  cmd_o.last_rd = 1'b1;
      rset_pkg::S_MOVE_WR: begin
        cmd_o.move_wr    = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = rset_pkg::STATUS_DONE;
      end
      rset_pkg::S_PICK_MOD: cmd_o.pick_rd = !sts_i.empty && sts_i.mod_done;
      rset_pkg::S_PICK_CAP: begin
        cmd_o.pick_cap   = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = rset_pkg::STATUS_DONE;
      end
      rset_pkg::S_FINISH: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rset_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/rset_dp.sv
module rset_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rset_pkg::cmd_t      cmd_i,
  output rset_pkg::sts_t      sts_o,
  input  rset_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rset_pkg::out_item_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic [rset_pkg::VALUE_W-1:0]  value_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 scan_idx_q, scan_idx_d;
  logic                          cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]                 cmp_idx_q;
  logic                          hit_q, hit_d;
  logic [AW-1:0]                 hit_pos_q, hit_pos_d;
  logic [rset_pkg::STATUS_W-1:0] status_q;
  logic [rset_pkg::VALUE_W-1:0]  picked_q;
  logic                          out_valid_q;
  rset_pkg::out_item_t           out_q;

  logic                          scan_issue;
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [rset_pkg::VALUE_W-1:0]  ram_wdata, ram_rdata;
  logic                          mod_done;
  logic [CW-1:0]                 mod_rem;

  rset_ram #(
    .WIDTH (rset_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rset_mod #(
    .CAPACITY (CAPACITY)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (in_data_i.random_in),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign scan_issue = cmd_i.scan && !hit_q && (scan_idx_q < count_q);

  always_comb begin
    ram_re    = scan_issue || cmd_i.last_rd || cmd_i.pick_rd;
    ram_raddr = AW'(scan_idx_q);
    if (cmd_i.last_rd) begin
      ram_raddr = AW'(count_q - CW'(1));
    end else if (cmd_i.pick_rd) begin
      ram_raddr = AW'(mod_rem);
    end
    ram_we    = cmd_i.append || cmd_i.move_wr;
    ram_waddr = cmd_i.move_wr ? hit_pos_q : AW'(count_q);
    ram_wdata = cmd_i.move_wr ? ram_rdata : value_q;
  end

  // search pipeline: issue one read per cycle, compare on the next
  always_comb begin
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = scan_issue;
    hit_d      = hit_q;
    hit_pos_d  = hit_pos_q;
    count_d    = count_q;
    if (scan_issue) begin
      scan_idx_d = scan_idx_q + CW'(1);
    end
    if (cmp_vld_q && !hit_q && (ram_rdata == value_q)) begin
      hit_d     = 1'b1;
      hit_pos_d = cmp_idx_q;
    end
    if (cmd_i.load) begin
      scan_idx_d = '0;
      cmp_vld_d  = 1'b0;
      hit_d      = 1'b0;
    end
    if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.move_wr) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_pos_q <= hit_pos_d;
    cmp_idx_q <= AW'(scan_idx_q);
    if (cmd_i.load) begin
      value_q  <= in_data_i.item_value;
      status_q <= rset_pkg::STATUS_NOP;
      picked_q <= '0;
    end else begin
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.pick_cap) begin
        picked_q <= ram_rdata;
      end
    end
    if (cmd_i.out_load) begin
      out_q.status       <= status_q;
      out_q.picked_value <= picked_q;
      out_q.count_after  <= rset_pkg::COUNT_W'(count_q);
    end
  end

  always_comb begin
    sts_o.scan_done = !cmp_vld_q && (hit_q || (scan_idx_q >= count_q));
    sts_o.hit       = hit_q;
    sts_o.full      = (count_q == CW'(CAPACITY));
    sts_o.empty     = (count_q == '0);
    sts_o.mod_done  = mod_done;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/randomized_set_table.sv
// set of distinct 32-bit values packed densely in a single-port-read store
// input channel: in_valid_i / in_stall_o / in_data_i (kind, item_value, random_in)
// output channel: out_valid_o / out_stall_i / out_data_o (status, picked_value,
// count_after); a transaction happens when valid is high and stall is low
// kinds: insert appends unless present or full, remove moves the last entry
// into the freed slot, pick returns entry (random_in mod count)
// one operation at a time; the next input transaction is taken once the
// previous result sits in the output register, even while it is stalled
// insert and remove: set by the linear search that reads one store entry per
// cycle; remove adds a read and a write state for the move
// pick: set by the 16-step bit-serial modulo unit
// pick on an empty set and other kind codes both return status 1
// reset clears the count and the handshakes; store contents need no clearing
// a stalled output holds its result and the block waits in its final state
module randomized_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rset_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rset_pkg::out_item_t out_data_o
);

  rset_pkg::cmd_t cmd;
  rset_pkg::sts_t sts;

  rset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rset_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
